/* sv/olst_pkg.sv */
package olst_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam int KIND_W = 3;
  localparam int POS_W  = 9;
  localparam int VAL_W  = 32;
  localparam int FI_W   = 8;
  localparam int LEN_W  = 9;
  localparam int ST_W   = 2;

  localparam logic [KIND_W-1:0] K_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] K_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] K_ERASE  = 3'd2;
  localparam logic [KIND_W-1:0] K_READ   = 3'd3;
  localparam logic [KIND_W-1:0] K_FIND   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic             find;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

/* sv/olst_cell.sv */
module olst_cell #(
  parameter int CAPACITY = olst_pkg::CAPACITY_DEF,
  parameter int IDX      = 0
) (
  input  logic                                           clk,
  input  olst_pkg::cell_ctl_t                            ctl,
  input  logic [$clog2(CAPACITY+1)-1:0]                  count,
  input  logic [olst_pkg::VAL_W-1:0]                     left_data,
  input  logic [olst_pkg::VAL_W-1:0]                     right_data,
  output logic [olst_pkg::VAL_W-1:0]                     data_o,
  input  logic                                           cin_hit,
  input  logic [olst_pkg::VAL_W-1:0]                     cin_data,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] cin_idx,
  output logic                                           cout_hit,
  output logic [olst_pkg::VAL_W-1:0]                     cout_data,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] cout_idx
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MW = (CW > olst_pkg::POS_W) ? CW : olst_pkg::POS_W;

  logic [olst_pkg::VAL_W-1:0] data_r, data_nxt;
  logic                       hit_r;
  logic [olst_pkg::VAL_W-1:0] cdat_r;
  logic [IW-1:0]              cidx_r;
  logic [MW-1:0]              pos_m, idx_m, cnt_m;
  logic                       hit;

  assign pos_m = MW'(ctl.pos);
  assign idx_m = MW'(IDX);
  assign cnt_m = MW'(count);

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (idx_m > pos_m) begin
        data_nxt = left_data;
      end else if (idx_m == pos_m) begin
        data_nxt = ctl.value;
      end
    end else if (ctl.del) begin
      if (idx_m >= pos_m) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // local match for the sweep
  assign hit = (idx_m < cnt_m) && (ctl.find ? (data_r == ctl.value) : (idx_m == pos_m));

  // first match wins along the chain
  always_ff @(posedge clk) begin
    if (cin_hit) begin
      hit_r  <= 1'b1;
      cdat_r <= cin_data;
      cidx_r <= cin_idx;
    end else if (hit) begin
      hit_r  <= 1'b1;
      cdat_r <= data_r;
      cidx_r <= IW'(IDX);
    end else begin
      hit_r  <= 1'b0;
      cdat_r <= '0;
      cidx_r <= '0;
    end
  end

  assign data_o    = data_r;
  assign cout_hit  = hit_r;
  assign cout_data = cdat_r;
  assign cout_idx  = cidx_r;

endmodule

/* sv/ordered_list_engine_unit.sv */
// channel  direction  words
// in_      input      in_kind, in_position, in_value
// out_     output     out_read_value, out_found_index, out_list_length, out_is_empty,
//                     out_status
//
// push, insert, erase and unused kinds finish without a sweep: every cell shifts at once
// read and find run a sweep through the registered match chain of the cells
// reset clears the count and control; entries hold garbage until written
// in_stall is high during a sweep and while a finished word waits on out_stall
// a stalled out_ word holds until taken
module ordered_list_engine_unit #(
  parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [olst_pkg::KIND_W-1:0]   in_kind,
  input  logic [olst_pkg::POS_W-1:0]    in_position,
  input  logic signed [olst_pkg::VAL_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [olst_pkg::VAL_W-1:0] out_read_value,
  output logic [olst_pkg::FI_W-1:0]     out_found_index,
  output logic [olst_pkg::LEN_W-1:0]    out_list_length,
  output logic                          out_is_empty,
  output logic [olst_pkg::ST_W-1:0]     out_status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MW = (CW > olst_pkg::POS_W) ? CW : olst_pkg::POS_W;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_SWEEP = 1'b1;

  logic                          state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [CW-1:0]                 sweep_cnt_r, sweep_cnt_nxt;
  logic                          op_find_r;
  logic [olst_pkg::POS_W-1:0]    op_pos_r;
  logic [olst_pkg::VAL_W-1:0]    op_val_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [olst_pkg::VAL_W-1:0]    out_rv_r, out_rv_nxt;
  logic [olst_pkg::FI_W-1:0]     out_fi_r, out_fi_nxt;
  logic [olst_pkg::LEN_W-1:0]    out_len_r, out_len_nxt;
  logic                          out_empty_r, out_empty_nxt;
  logic [olst_pkg::ST_W-1:0]     out_st_r, out_st_nxt;

  logic                          acc, out_free, full, sweep_done;
  logic                          ins_ok, del_ok, need_sweep;
  logic [olst_pkg::ST_W-1:0]     imm_st;
  logic [MW-1:0]                 pos_m, cnt_m;
  olst_pkg::cell_ctl_t           ctl;

  logic [olst_pkg::VAL_W-1:0]    data_w  [CAPACITY];
  logic                          chit_w  [CAPACITY];
  logic [olst_pkg::VAL_W-1:0]    cdat_w  [CAPACITY];
  logic [IW-1:0]                 cidx_w  [CAPACITY];

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == S_IDLE) && out_free);
  assign acc        = in_valid && !in_stall;
  assign full       = (count_r == CW'(CAPACITY));
  assign pos_m      = MW'(in_position);
  assign cnt_m      = MW'(count_r);
  assign sweep_done = (state_r == S_SWEEP) && (sweep_cnt_r == CW'(CAPACITY));

  always_comb begin
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    need_sweep = 1'b0;
    imm_st     = olst_pkg::ST_OK;
    case (in_kind)
      olst_pkg::K_PUSH: begin
        if (full) begin
          imm_st = olst_pkg::ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      olst_pkg::K_INSERT: begin
        if (pos_m > cnt_m) begin
          imm_st = olst_pkg::ST_RANGE;
        end else if (full) begin
          imm_st = olst_pkg::ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      olst_pkg::K_ERASE: begin
        if (pos_m >= cnt_m) begin
          imm_st = olst_pkg::ST_RANGE;
        end else begin
          del_ok = 1'b1;
        end
      end
      olst_pkg::K_READ, olst_pkg::K_FIND: begin
        need_sweep = 1'b1;
      end
      default: begin
        imm_st = olst_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    ctl.ins   = acc && ins_ok;
    ctl.del   = acc && del_ok;
    ctl.find  = op_find_r;
    ctl.pos   = (state_r == S_IDLE) ?
                ((in_kind == olst_pkg::K_PUSH) ? '0 : in_position) : op_pos_r;
    ctl.value = (state_r == S_IDLE) ? in_value : op_val_r;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [olst_pkg::VAL_W-1:0] left_d, right_d;
      logic                       cin_h;
      logic [olst_pkg::VAL_W-1:0] cin_d;
      logic [IW-1:0]              cin_i;
      if (g == 0) begin : g_first
        assign left_d = in_value;
        assign cin_h  = 1'b0;
        assign cin_d  = '0;
        assign cin_i  = '0;
      end else begin : g_mid
        assign left_d = data_w[g-1];
        assign cin_h  = chit_w[g-1];
        assign cin_d  = cdat_w[g-1];
        assign cin_i  = cidx_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_d = data_w[g];
      end else begin : g_inner
        assign right_d = data_w[g+1];
      end
      olst_cell #(
        .CAPACITY (CAPACITY),
        .IDX      (g)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .count      (count_r),
        .left_data  (left_d),
        .right_data (right_d),
        .data_o     (data_w[g]),
        .cin_hit    (cin_h),
        .cin_data   (cin_d),
        .cin_idx    (cin_i),
        .cout_hit   (chit_w[g]),
        .cout_data  (cdat_w[g]),
        .cout_idx   (cidx_w[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rv_nxt    = out_rv_r;
    out_fi_nxt    = out_fi_r;
    out_len_nxt   = out_len_r;
    out_empty_nxt = out_empty_r;
    out_st_nxt    = out_st_r;
    if (acc) begin
      if (need_sweep) begin
        state_nxt     = S_SWEEP;
        sweep_cnt_nxt = '0;
      end else begin
        if (ins_ok) begin
          count_nxt = count_r + CW'(1);
        end else if (del_ok) begin
          count_nxt = count_r - CW'(1);
        end
        out_valid_nxt = 1'b1;
        out_rv_nxt    = '0;
        out_fi_nxt    = '0;
        out_len_nxt   = olst_pkg::LEN_W'(count_nxt);
        out_empty_nxt = (count_nxt == '0);
        out_st_nxt    = imm_st;
      end
    end else if (state_r == S_SWEEP) begin
      if (!sweep_done) begin
        sweep_cnt_nxt = sweep_cnt_r + CW'(1);
      end else if (out_free) begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_rv_nxt    = (!op_find_r && chit_w[CAPACITY-1]) ? cdat_w[CAPACITY-1] : '0;
        out_fi_nxt    = (op_find_r && chit_w[CAPACITY-1]) ?
                        olst_pkg::FI_W'(cidx_w[CAPACITY-1]) : '0;
        out_len_nxt   = olst_pkg::LEN_W'(count_r);
        out_empty_nxt = (count_r == '0);
        out_st_nxt    = chit_w[CAPACITY-1] ? olst_pkg::ST_OK :
                        (op_find_r ? olst_pkg::ST_MISS : olst_pkg::ST_RANGE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
      op_find_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        op_find_r <= (in_kind == olst_pkg::K_FIND);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_pos_r <= in_position;
      op_val_r <= in_value;
    end
    out_rv_r    <= out_rv_nxt;
    out_fi_r    <= out_fi_nxt;
    out_len_r   <= out_len_nxt;
    out_empty_r <= out_empty_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_rv_r;
  assign out_found_index = out_fi_r;
  assign out_list_length = out_len_r;
  assign out_is_empty    = out_empty_r;
  assign out_status      = out_st_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && ins_ok) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the list");

  a_erase_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && del_ok) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("erase did not shrink the list");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (sweep_cnt_r <= CW'(CAPACITY)))
    else $error("sweep counter overran");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r == olst_pkg::ST_MISS)) |-> (out_fi_r == '0 && out_rv_r == '0))
    else $error("miss word carries a result");

endmodule
